[hw/rtl/tbpf_pkg.sv]
`default_nettype none
package tbpf_pkg;

    // Input kind codes on s_tuser
    localparam logic [1:0] KIND_VWRITE = 2'd0;
    localparam logic [1:0] KIND_PWRITE = 2'd1;
    localparam logic [1:0] KIND_RENDER = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_CHR_OFFSET  = 2'd0;
    localparam logic [1:0] REG_TMAP_OFFSET = 2'd1;
    localparam logic [1:0] REG_COLOR_256   = 2'd2;

    localparam int BASE_W   = 17;
    // Widest byte-address sum before wrapping
    localparam int SUM_W    = 18;
    localparam int Q_DEPTH  = 2;
    localparam int PAL_DEPTH = 256;
    localparam int PAL_W    = 15;

    typedef enum logic [1:0] {
        OP_VWRITE,
        OP_PWRITE,
        OP_RENDER
    } op_t;

    typedef struct packed {
        logic [BASE_W-1:0] chr_offset;
        logic [BASE_W-1:0] tmap_offset;
        logic              color_256;
    } cfg_t;

    typedef struct packed {
        op_t              op;
        logic [15:0]      addr;
        logic [15:0]      data;
        logic [2:0]       col;
        logic [2:0]       row;
        logic [SUM_W-1:0] map_byte;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_T0,
        ST_T1,
        ST_T2,
        ST_PAL
    } state_t;

    function automatic logic [23:0] expand_color(input logic [PAL_W-1:0] c);
        expand_color = {c[14:10], 3'b000, c[9:5], 3'b000, c[4:0], 3'b000};
    endfunction

endpackage
`default_nettype wire

[hw/rtl/tile_background_pixel_fetch.sv]
// Text-mode background pixel engine for one 32x32 tile layer. Input beats carry a video
// memory halfword write, a palette write or a pixel render (kind on s_tuser); only renders
// produce an output beat, with RGB888 colour on m_tdata and the transparent flag on m_tuser.
// A two-entry queue separates the decode stage from the fetch sequencer, and an output
// register lets a new beat in while a result waits. Writes finish in the idle state.
// A render does a map read, one (256-colour) or three (16-colour) tile halfword reads in
// series on the single video memory read port, then a palette read. VIDEO_HALFWORDS must
// be a power of two; addresses wrap at it. The user must write the registers through
// cfg_we/cfg_index/cfg_data only while no item is in flight; the block does not enforce it.
`default_nettype none
module tile_background_pixel_fetch
    import tbpf_pkg::*;
#(
    parameter int VIDEO_HALFWORDS = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // addr[15:0], data[31:16], px_x[39:32], px_y[47:40]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // color[23:0]
    output logic             m_tuser,   // transparent[0]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  push;
    item_t push_item;
    logic  full;
    logic  pop;
    logic  head_valid;
    item_t head_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CHR_OFFSET:  cfg_next.chr_offset  = cfg_data;
                REG_TMAP_OFFSET: cfg_next.tmap_offset = cfg_data;
                REG_COLOR_256:   cfg_next.color_256   = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tbpf_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .full     (full),
        .push     (push),
        .item     (push_item)
    );

    tbpf_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    tbpf_back #(
        .VIDEO_HALFWORDS (VIDEO_HALFWORDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire

[hw/rtl/tbpf_ram.sv]
`default_nettype none
module tbpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[hw/rtl/tbpf_front.sv]
`default_nettype none
module tbpf_front
    import tbpf_pkg::*;
(
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire cfg_t        cfg,
    input  wire logic        full,
    output logic             push,
    output item_t            item
);

    logic [SUM_W-1:0] map_sum;
    logic [7:0]       x;
    logic [7:0]       y;
    logic             known;

    assign x = s_tdata[39:32];
    assign y = s_tdata[47:40];

    // Map entry byte address, bit 0 dropped
    assign map_sum = SUM_W'(cfg.tmap_offset) + SUM_W'({y[7:3], x[7:3], 1'b0});

    always_comb
    begin
        item.addr     = s_tdata[15:0];
        item.data     = s_tdata[31:16];
        item.col      = x[2:0];
        item.row      = y[2:0];
        item.map_byte = {map_sum[SUM_W-1:1], 1'b0};
        item.op       = OP_RENDER;
        known         = 1'b1;
        case (s_tuser)
            KIND_VWRITE: item.op = OP_VWRITE;
            KIND_PWRITE: item.op = OP_PWRITE;
            KIND_RENDER: item.op = OP_RENDER;
            default:     known   = 1'b0;
        endcase
    end

    // Unknown kinds are taken and dropped
    assign s_tready = !full;
    assign push     = s_tvalid && !full && known;

endmodule
`default_nettype wire

[hw/rtl/tbpf_fifo.sv]
`default_nettype none
module tbpf_fifo
    import tbpf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output item_t      head_item
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    item_t          slot_reg [Q_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign full       = (count_reg == CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/tbpf_back.sv]
`default_nettype none
module tbpf_back
    import tbpf_pkg::*;
#(
    parameter int VIDEO_HALFWORDS = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        head_valid,
    input  wire item_t       head_item,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic             m_tuser
);

    localparam int AW = $clog2(VIDEO_HALFWORDS);
    localparam int BW = AW + 1;

    state_t state_reg;
    state_t state_next;

    logic          vram_we;
    logic          vram_re;
    logic [AW-1:0] vram_raddr;
    logic [15:0]   vram_rdata;
    logic          pal_we;
    logic          pal_re;
    logic [7:0]    pal_raddr;
    logic [PAL_W-1:0] pal_rdata;

    logic [2:0]    col_reg;
    logic [2:0]    col_next;
    logic [2:0]    row_reg;
    logic [2:0]    row_next;
    logic [3:0]    slot_reg;
    logic [3:0]    slot_next;
    logic [AW-1:0] thw_reg;
    logic [AW-1:0] thw_next;
    logic          odd_reg;
    logic          odd_next;
    logic [15:0]   h0_reg;
    logic [15:0]   h0_next;
    logic [15:0]   h1_reg;
    logic [15:0]   h1_next;
    logic [7:0]    idx_reg;
    logic [7:0]    idx_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [23:0]   out_color_reg;
    logic [23:0]   out_color_next;
    logic          out_transp_reg;
    logic          out_transp_next;

    logic [2:0]       col_f;
    logic [2:0]       row_f;
    logic [SUM_W-1:0] tile_base;
    logic [SUM_W-1:0] tile_byte;
    logic [BW-1:0]    tile_wrap;
    logic [BW-1:0]    map_wrap;
    logic [31:0]      planes;
    logic [3:0]       idx4;
    logic             out_free;

    assign map_wrap = BW'(head_item.map_byte);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        col_f     = vram_rdata[10] ? ~col_reg : col_reg;
        row_f     = vram_rdata[11] ? ~row_reg : row_reg;
        tile_base = SUM_W'(cfg.chr_offset)
                  + (cfg.color_256 ? SUM_W'({vram_rdata[9:0], 6'b0})
                                   : SUM_W'({vram_rdata[9:0], 5'b0}));
        tile_byte = cfg.color_256 ? tile_base + SUM_W'({row_f, col_f})
                                  : tile_base + SUM_W'({row_f, 2'b00});
        tile_wrap = BW'(tile_byte);
        // Four plane bytes starting at an even or odd byte
        planes    = odd_reg ? {vram_rdata[7:0], h1_reg, h0_reg[15:8]}
                            : {h1_reg, h0_reg};
        for (int p = 0; p < 4; p++)
        begin
            idx4[p] = planes[{2'(p), ~col_reg}];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pop             = 1'b0;
        vram_we         = 1'b0;
        vram_re         = 1'b0;
        vram_raddr      = thw_reg;
        pal_we          = 1'b0;
        pal_re          = 1'b0;
        pal_raddr       = {slot_reg, idx4};
        col_next        = col_reg;
        row_next        = row_reg;
        slot_next       = slot_reg;
        thw_next        = thw_reg;
        odd_next        = odd_reg;
        h0_next         = h0_reg;
        h1_next         = h1_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_color_next  = out_color_reg;
        out_transp_next = out_transp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    case (head_item.op)
                        OP_VWRITE: vram_we = 1'b1;
                        OP_PWRITE: pal_we  = 1'b1;
                        OP_RENDER:
                        begin
                            vram_re    = 1'b1;
                            vram_raddr = map_wrap[BW-1:1];
                            col_next   = head_item.col;
                            row_next   = head_item.row;
                            state_next = ST_MAP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAP:
            begin
                slot_next  = vram_rdata[15:12];
                col_next   = col_f;
                row_next   = row_f;
                thw_next   = tile_wrap[BW-1:1];
                odd_next   = tile_wrap[0];
                vram_re    = 1'b1;
                vram_raddr = tile_wrap[BW-1:1];
                state_next = ST_T0;
            end
            ST_T0:
            begin
                if (cfg.color_256)
                begin
                    idx_next   = odd_reg ? vram_rdata[15:8] : vram_rdata[7:0];
                    pal_re     = 1'b1;
                    pal_raddr  = idx_next;
                    state_next = ST_PAL;
                end
                else
                begin
                    h0_next    = vram_rdata;
                    vram_re    = 1'b1;
                    vram_raddr = thw_reg + AW'(1);
                    state_next = ST_T1;
                end
            end
            ST_T1:
            begin
                h1_next    = vram_rdata;
                vram_re    = 1'b1;
                vram_raddr = thw_reg + AW'(2);
                state_next = ST_T2;
            end
            ST_T2:
            begin
                idx_next   = {4'b0000, idx4};
                pal_re     = 1'b1;
                pal_raddr  = {slot_reg, idx4};
                state_next = ST_PAL;
            end
            ST_PAL:
            begin
                // Hold the palette word until the output register frees up
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_transp_next = (idx_reg == 8'd0);
                    out_color_next  = (idx_reg == 8'd0) ? 24'd0 : expand_color(pal_rdata);
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg        <= col_next;
        row_reg        <= row_next;
        slot_reg       <= slot_next;
        thw_reg        <= thw_next;
        odd_reg        <= odd_next;
        h0_reg         <= h0_next;
        h1_reg         <= h1_next;
        idx_reg        <= idx_next;
        out_color_reg  <= out_color_next;
        out_transp_reg <= out_transp_next;
    end

    tbpf_ram #(
        .WIDTH (16),
        .DEPTH (VIDEO_HALFWORDS)
    ) u_vram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (AW'(head_item.addr)),
        .wdata (head_item.data),
        .re    (vram_re),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    tbpf_ram #(
        .WIDTH (PAL_W),
        .DEPTH (PAL_DEPTH)
    ) u_pal (
        .clk   (clk),
        .we    (pal_we),
        .waddr (head_item.addr[7:0]),
        .wdata (head_item.data[PAL_W-1:0]),
        .re    (pal_re),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_color_reg;
    assign m_tuser  = out_transp_reg;

endmodule
`default_nettype wire

[hw/rtl/tbpf_checker.sv]
`default_nettype none
module tbpf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output payload changed while stalled");

    a_transp_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 24'd0)
        else $error("transparent pixel with non-zero colour");

    a_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] == 3'd0 && m_tdata[10:8] == 3'd0
                     && m_tdata[18:16] == 3'd0)
        else $error("colour channel low bits not clear");

endmodule

bind tile_background_pixel_fetch tbpf_checker u_tbpf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

[verif/tile_background_pixel_fetch_tb.sv]
`timescale 1ns / 1ps
module tile_background_pixel_fetch_tb;
    import tbpf_pkg::*;

    localparam int          VIDEO_HW    = 65536;
    localparam int          ITEMS       = 1350;
    localparam int          PHASES      = 6;
    localparam int          SETTLE      = 12;
    localparam int          HOLD_CYCLES = 80;
    localparam int          STALL_LIMIT = 3000;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;

    class tile_pixel_board;
        bit [15:0] vram [VIDEO_HW];
        bit [14:0] palette [256];
        bit [16:0] chr_offset;
        bit [16:0] tmap_offset;
        bit        color_256;
        bit [24:0] pending_pixels [$];   // {color, transparent}
        int        errors;

        function void set_config(bit [16:0] cb, bit [16:0] mb, bit c256);
            chr_offset  = cb;
            tmap_offset = mb;
            color_256   = c256;
        endfunction

        function bit [15:0] map_hw(bit [7:0] x, bit [7:0] y);
            bit [16:0] a;
            a = tmap_offset + {6'd0, y[7:3], x[7:3], 1'b0};
            return a[16:1];
        endfunction

        function bit [7:0] vram_byte(bit [16:0] a);
            bit [15:0] h;
            h = vram[a[16:1]];
            return a[0] ? h[15:8] : h[7:0];
        endfunction

        function void locate(bit [7:0] x, bit [7:0] y, output bit [15:0] entry,
                             output bit [2:0] col, output bit [2:0] row);
            entry = vram[map_hw(x, y)];
            col   = entry[10] ? 3'd7 - x[2:0] : x[2:0];
            row   = entry[11] ? 3'd7 - y[2:0] : y[2:0];
        endfunction

        // Byte address of one bit plane (4bpp) or of the whole index (8bpp)
        function bit [16:0] tile_byte(bit [7:0] x, bit [7:0] y, bit [1:0] plane);
            bit [15:0] e;
            bit [2:0]  c;
            bit [2:0]  r;
            bit [16:0] base;
            bit [16:0] a;
            locate(x, y, e, c, r);
            if (color_256)
            begin
                base = chr_offset + {1'b0, e[9:0], 6'd0};
                a    = base + {11'd0, r, c};
            end
            else
            begin
                base = chr_offset + {2'b0, e[9:0], 5'd0};
                a    = base + {12'd0, r, plane};
            end
            return a;
        endfunction

        function bit [7:0] pixel_index(bit [7:0] x, bit [7:0] y);
            bit [15:0] e;
            bit [2:0]  c;
            bit [2:0]  r;
            bit [7:0]  b;
            bit [7:0]  idx;
            locate(x, y, e, c, r);
            if (color_256)
                return vram_byte(tile_byte(x, y, 2'd0));
            idx = 8'd0;
            for (int p = 0; p < 4; p++)
            begin
                b      = vram_byte(tile_byte(x, y, p[1:0]));
                idx[p] = b[3'd7 - c];
            end
            return idx;
        endfunction

        function bit [7:0] palette_slot(bit [7:0] x, bit [7:0] y);
            bit [15:0] e;
            bit [2:0]  c;
            bit [2:0]  r;
            bit [7:0]  idx;
            locate(x, y, e, c, r);
            idx = pixel_index(x, y);
            return color_256 ? idx : {e[15:12], idx[3:0]};
        endfunction

        function void note_input(logic [1:0] kind, logic [15:0] addr, logic [15:0] data,
                                 logic [7:0] x, logic [7:0] y);
            bit [14:0] c;
            case (kind)
                KIND_VWRITE: vram[addr] = data;
                KIND_PWRITE: palette[addr[7:0]] = data[14:0];
                KIND_RENDER:
                begin
                    if (pixel_index(x, y) == 8'd0)
                        pending_pixels.push_back({24'd0, 1'b1});
                    else
                    begin
                        c = palette[palette_slot(x, y)];
                        pending_pixels.push_back({c[14:10], 3'b000, c[9:5], 3'b000,
                                                  c[4:0], 3'b000, 1'b0});
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [23:0] color, logic transp);
            bit [24:0] want;
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected pixel beat: color %h transparent %b", color, transp);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (color !== want[24:1])
            begin
                $error("color: expected %h, got %h", want[24:1], color);
                errors++;
            end
            if (transp !== want[0])
            begin
                $error("transparent: expected %b, got %b", want[0], transp);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // addr[15:0], data[31:16], px_x[39:32], px_y[47:40]
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // color[23:0]
    logic        m_tuser;   // transparent[0]
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    tile_pixel_board board = new();
    bit              vram_written [VIDEO_HW];
    bit              palette_written [256];
    int              items_sent;
    int              stalled_cycles;
    bit              gaps_on = 1'b1;
    bit              hold_req;

    tile_background_pixel_fetch #(
        .VIDEO_HALFWORDS(VIDEO_HW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit [15:0] tile_word();
        bit [15:0] w;
        w = 16'($urandom_range(0, 65535));
        return ($urandom_range(0, 5) == 0) ? 16'h0000 : w;
    endfunction

    function automatic bit [15:0] map_entry_word();
        bit [15:0] e;
        e = 16'($urandom_range(0, 65535));
        // keep most tiles in a small pool so tile data gets reused
        if ($urandom_range(0, 3) != 0)
            e[9:5] = 5'd0;
        return e;
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [15:0] addr,
                             input logic [15:0] data, input logic [7:0] x,
                             input logic [7:0] y);
        while (gaps_on && $urandom_range(0, 99) < 37)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {y, x, data, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_input(kind, addr, data, x, y);
        if (kind == KIND_VWRITE)
            vram_written[addr] = 1'b1;
        if (kind == KIND_PWRITE)
            palette_written[addr[7:0]] = 1'b1;
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    // Fill whatever the pixel will read that holds nothing yet, then render it
    task automatic render_px(input bit [7:0] x, input bit [7:0] y, input bit rewrite,
                             input bit [15:0] entry);
        bit [15:0] mh;
        bit [16:0] first_byte;
        bit [15:0] h0;
        bit [15:0] h;
        bit [7:0]  slot;
        int        n;
        mh = board.map_hw(x, y);
        if (rewrite || !vram_written[mh])
            send_item(KIND_VWRITE, mh, rewrite ? entry : map_entry_word(),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        first_byte = board.tile_byte(x, y, 2'd0);
        h0 = first_byte[16:1];
        n  = board.color_256 ? 1 : 3;
        for (int i = 0; i < n; i++)
        begin
            h = h0 + i[15:0];
            if (!vram_written[h])
                send_item(KIND_VWRITE, h, tile_word(),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        slot = board.palette_slot(x, y);
        if (!palette_written[slot])
            send_item(KIND_PWRITE, {8'($urandom_range(0, 255)), slot},
                      16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        send_item(KIND_RENDER, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), x, y);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_pixels.size() != 0);
    endtask

    task automatic load_config(input bit [16:0] cb, input bit [16:0] mb, input bit c256);
        drain_results();
        // writes leave no beat behind, so let the queue empty out
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CHR_OFFSET;
        cfg_data  <= cb;
        @(posedge clk);
        cfg_index <= REG_TMAP_OFFSET;
        cfg_data  <= mb;
        @(posedge clk);
        cfg_index <= REG_COLOR_256;
        cfg_data  <= {16'd0, c256};
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_config(cb, mb, c256);
    endtask

    task automatic directed_items();
        // high palette address bits and data bit 15 are dropped
        send_item(KIND_PWRITE, 16'hFF00, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(KIND_PWRITE, 16'h00FF, 16'h0000, 8'h00, 8'h00);
        send_item(KIND_VWRITE, 16'hFFFF, 16'hFFFF, 8'h00, 8'hFF);
        // clear row 0 of tile 5 for a transparent pixel
        send_item(KIND_VWRITE, 16'd80, 16'h0000, 8'h00, 8'h00);
        send_item(KIND_VWRITE, 16'd81, 16'h0000, 8'h00, 8'h00);
        send_item(KIND_VWRITE, 16'd82, 16'h0000, 8'h00, 8'h00);
        render_px(8'd8, 8'd0, 1'b1, 16'h0005);
        render_px(8'd255, 8'd255, 1'b1, 16'hFFFF);
        render_px(8'd0, 8'd0, 1'b1, 16'h1401);
        render_px(8'd7, 8'd7, 1'b1, 16'h2802);
        send_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        render_px(8'd255, 8'd0, 1'b0, 16'h0000);
        render_px(8'd0, 8'd255, 1'b0, 16'h0000);
    endtask

    task automatic random_item();
        int       r;
        bit [7:0] x;
        bit [7:0] y;
        r = $urandom_range(0, 99);
        x = 8'($urandom_range(0, 255));
        y = 8'($urandom_range(0, 255));
        if (r < 70)
            render_px(x, y, 1'b0, 16'h0000);
        else if (r < 80)
            render_px(x, y, 1'b1, map_entry_word());
        else if (r < 88)
            send_item(KIND_VWRITE, 16'($urandom_range(0, 65535)), tile_word(), x, y);
        else if (r < 95)
            send_item(KIND_PWRITE, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), x, y);
        else
            send_item(KIND_UNUSED, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), x, y);
    endtask

    initial
    begin
        int        stop_at;
        bit [16:0] cb;
        bit [16:0] mb;
        bit        c256;
        bit        held;
        bit        paused;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_VWRITE;
        cfg_we    = 1'b0;
        cfg_index = REG_CHR_OFFSET;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin cb = 17'd0; mb = 17'd0; c256 = 1'b0; end
                1: begin cb = 17'h1FFFF; mb = 17'h1FFFF; c256 = 1'b1; end
                2: begin cb = 17'($urandom_range(0, 131071));
                         mb = 17'($urandom_range(0, 131071));
                         c256 = 1'b0; end
                3: begin cb = 17'($urandom_range(0, 131071));
                         mb = 17'($urandom_range(0, 131071));
                         c256 = 1'b1; end
                4: begin cb = 17'h1FFFF; mb = 17'd0; c256 = 1'b0; end
                default: begin cb = 17'd0; mb = 17'h1FFFF; c256 = 1'b1; end
            endcase
            load_config(cb, mb, c256);
            gaps_on = (ph != 1);
            if (ph == 0)
                directed_items();
            stop_at = (ph + 1) * ITEMS / PHASES;
            while (items_sent < stop_at)
            begin
                if (ph == 2 && !held && items_sent >= stop_at - 150)
                begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                if (ph == 3 && !paused && items_sent >= stop_at - 100)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                random_item();
            end
        end
        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (board.errors == 0 && board.pending_pixels.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int hold_cnt;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            // hold off long enough for the input side to back up
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(gaps_on && $urandom_range(0, 99) < 37);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
